FILE: rtl/rrape_pkg.sv
// Package: AES types, register indices, S-box, round constants and round functions.
package rrape_pkg;

   typedef logic [127:0] block_type;

   localparam int unsigned REG_KEY_LOW     = 0;
   localparam int unsigned REG_KEY_HIGH    = 1;
   localparam int unsigned REG_BASE_LOW    = 2;
   localparam int unsigned REG_BASE_HIGH   = 3;
   localparam int unsigned REG_ROUND_COUNT = 4;
   localparam int unsigned REG_ACTIVE_MAP  = 5;
   localparam int unsigned REG_PASSIVE_MAP = 6;
   localparam int unsigned AES_ROUNDS      = 10;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] RCON [AES_ROUNDS] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
   };

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic block_type next_key(input block_type prev, input logic [7:0] rc);
      logic [31:0] t;
      block_type   nk;
      t = {SBOX[prev[103:96]], SBOX[prev[127:120]], SBOX[prev[119:112]],
           SBOX[prev[111:104]] ^ rc};
      nk[31:0] = prev[31:0] ^ t;
      for (int w = 1; w < 4; w++) begin
         nk[32*w +: 32] = prev[32*w +: 32] ^ nk[32*(w-1) +: 32];
      end
      return nk;
   endfunction

   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(r + 4*c) +: 8] = SBOX[s[8*(r + 4*((c + r) % 4)) +: 8]];
         end
      end
      return t;
   endfunction

   function automatic block_type mix_columns(input block_type s);
      block_type  t;
      logic [7:0] a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0  = s[32*c +: 8];
         a1  = s[32*c + 8 +: 8];
         a2  = s[32*c + 16 +: 8];
         a3  = s[32*c + 24 +: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[32*c +: 8]      = a0 ^ all ^ xtime(a0 ^ a1);
         t[32*c + 8 +: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
         t[32*c + 16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[32*c + 24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

endpackage

FILE: rtl/rrape_stream_if.sv
// Interface: valid/ready channel with a generic payload.
interface rrape_stream_if #(
   parameter int unsigned WIDTH = 32
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rrape_round.sv
// One pipelined AES round stage with its own key expansion step; stages past the round count pass state and key.
module rrape_round
   import rrape_pkg::*;
#(
   parameter int unsigned INDEX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      valid_in,
   input  block_type state_in,
   input  block_type key_in,
   input  logic [3:0] rounds_in,
   input  logic [63:0] sel_in,
   output logic      valid_out,
   output block_type state_out,
   output block_type key_out,
   output logic [3:0] rounds_out,
   output logic [63:0] sel_out
);
   localparam logic [3:0] RNUM = 4'(INDEX + 1);

   logic      valid_ff;
   block_type state_ff, state_in_c, key_ff, key_in_c, ss;
   logic [3:0] rounds_ff;
   logic [63:0] sel_ff;

   always_comb begin
      key_in_c = next_key(key_in, RCON[INDEX]);
      ss       = sub_shift(state_in);
      if (RNUM > rounds_in) begin
         state_in_c = state_in;
         key_in_c   = key_in;
      end else if (RNUM < rounds_in) begin
         state_in_c = mix_columns(ss) ^ key_in_c;
      end else begin
         state_in_c = ss ^ key_in_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         state_ff  <= state_in_c;
         key_ff    <= key_in_c;
         rounds_ff <= rounds_in;
         sel_ff    <= sel_in;
      end
   end

   assign valid_out  = valid_ff;
   assign state_out  = state_ff;
   assign key_out    = key_ff;
   assign rounds_out = rounds_ff;
   assign sel_out    = sel_ff;
endmodule

FILE: rtl/reduced_round_aes_partial_encrypt.sv
// Top level: reduced-round AES-128 partial encryptor with APB config.
// An accepted word passes an input register, the round registers and an output register.
// Throughput: one word per cycle unless stalled; one round register stage per AES round.
// Stalls hold the whole pipeline; no word is lost or repeated.
// Reset clears valid bits and config registers; round_count resets to 10.
module reduced_round_aes_partial_encrypt
   import rrape_pkg::*;
#(
   parameter int unsigned MAX_ACTIVE  = 4,
   parameter int unsigned MAX_PASSIVE = 8,
   parameter int unsigned MAX_ROUNDS  = 10
) (
   input  logic        clock,
   input  logic        reset,
   rrape_stream_if.sink   req,
   rrape_stream_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   localparam int unsigned ACT_LIM = (MAX_ACTIVE < 4) ? MAX_ACTIVE : 4;
   localparam int unsigned PAS_LIM = (MAX_PASSIVE < 8) ? MAX_PASSIVE : 8;

   logic [63:0] key_low_ff, key_high_ff, base_low_ff, base_high_ff;
   logic [3:0]  round_count_ff;
   logic [18:0] active_map_ff;
   logic [35:0] passive_map_ff;
   logic        wr;
   logic [2:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[5:3];
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff     <= '0;
         key_high_ff    <= '0;
         base_low_ff    <= '0;
         base_high_ff   <= '0;
         round_count_ff <= 4'd10;
         active_map_ff  <= '0;
         passive_map_ff <= '0;
      end else if (wr && csr_paddr[2:0] == 3'd0) begin
         unique case (32'(reg_idx))
            REG_KEY_LOW:     key_low_ff     <= csr_pwdata;
            REG_KEY_HIGH:    key_high_ff    <= csr_pwdata;
            REG_BASE_LOW:    base_low_ff    <= csr_pwdata;
            REG_BASE_HIGH:   base_high_ff   <= csr_pwdata;
            REG_ROUND_COUNT: round_count_ff <= csr_pwdata[3:0];
            REG_ACTIVE_MAP:  active_map_ff  <= csr_pwdata[18:0];
            REG_PASSIVE_MAP: passive_map_ff <= csr_pwdata[35:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (32'(reg_idx))
         REG_KEY_LOW:     csr_prdata = key_low_ff;
         REG_KEY_HIGH:    csr_prdata = key_high_ff;
         REG_BASE_LOW:    csr_prdata = base_low_ff;
         REG_BASE_HIGH:   csr_prdata = base_high_ff;
         REG_ROUND_COUNT: csr_prdata = 64'(round_count_ff);
         REG_ACTIVE_MAP:  csr_prdata = 64'(active_map_ff);
         REG_PASSIVE_MAP: csr_prdata = 64'(passive_map_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Pipeline control: advance while the output is free or drained.
   logic advance;
   logic [MAX_ROUNDS+1:0] vchain;
   block_type st [MAX_ROUNDS+1];
   block_type ky [MAX_ROUNDS+1];
   logic [3:0] rn [MAX_ROUNDS+1];
   logic [63:0] sl [MAX_ROUNDS+1];

   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // Stage 0: build plaintext, initial key add.
   logic [3:0]  rounds_c;
   logic [2:0]  nact;
   logic [3:0]  npas;
   block_type   pt;
   logic [63:0] sel_c;
   logic        v0_ff;
   block_type   s0_ff, k0_ff;
   logic [3:0]  r0_ff;
   logic [63:0] l0_ff;

   always_comb begin
      rounds_c = round_count_ff;
      if (rounds_c == 4'd0) rounds_c = 4'd1;
      if (rounds_c > 4'(MAX_ROUNDS)) rounds_c = 4'(MAX_ROUNDS);
      nact = active_map_ff[2:0];
      if (nact > 3'(ACT_LIM)) nact = 3'(ACT_LIM);
      npas = passive_map_ff[3:0];
      if (npas > 4'(PAS_LIM)) npas = 4'(PAS_LIM);
      pt = {base_high_ff, base_low_ff};
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < nact) begin
            pt[8*active_map_ff[4*k+3 +: 4] +: 8] = req.data[8*k +: 8];
         end
      end
      sel_c = '0;
      for (int k = 0; k < 8; k++) begin
         sel_c[8*k +: 8] = {npas > 4'(k), 3'd0, passive_map_ff[4*k+4 +: 4]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req.valid;
      end
      if (advance) begin
         s0_ff <= pt ^ {key_high_ff, key_low_ff};
         k0_ff <= {key_high_ff, key_low_ff};
         r0_ff <= rounds_c;
         l0_ff <= sel_c;
      end
   end

   assign vchain[0] = v0_ff;
   assign st[0] = s0_ff;
   assign ky[0] = k0_ff;
   assign rn[0] = r0_ff;
   assign sl[0] = l0_ff;

   for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_round
      rrape_round #(.INDEX(g)) u_round (
         .clock(clock), .reset(reset), .advance(advance),
         .valid_in(vchain[g]), .state_in(st[g]), .key_in(ky[g]),
         .rounds_in(rn[g]), .sel_in(sl[g]),
         .valid_out(vchain[g+1]), .state_out(st[g+1]), .key_out(ky[g+1]),
         .rounds_out(rn[g+1]), .sel_out(sl[g+1])
      );
   end

   // Output stage: pick ciphertext bytes.
   logic        vo_ff;
   logic [63:0] out_ff, out_c;
   block_type   ct;

   assign ct = st[MAX_ROUNDS];
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         out_c[8*k +: 8] = sl[MAX_ROUNDS][8*k+7] ? ct[8*sl[MAX_ROUNDS][8*k +: 4] +: 8] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (advance) begin
         vo_ff <= vchain[MAX_ROUNDS];
      end
      if (advance) begin
         out_ff <= out_c;
      end
   end

   assign vchain[MAX_ROUNDS+1] = vo_ff;

   assign rsp.valid = vchain[MAX_ROUNDS+1];
   assign rsp.data  = out_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result word dropped under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("input ready mismatch");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      advance && v0_ff |=> vchain[1])
      else $error("word lost in first round stage");
endmodule

FILE: test/tb_reduced_round_aes_partial_encrypt.sv
// Testbench: reduced-round AES partial encryptor against a built-in predictor.
module tb_reduced_round_aes_partial_encrypt;
   import rrape_pkg::*;

   localparam logic [7:0] SB [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };
   localparam logic [7:0] RC [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
                                      8'h1B, 8'h36};
   localparam int LIMIT = 400000;

   class ct_scoreboard;
      logic [63:0] key_lo, key_hi, base_lo, base_hi;
      logic [3:0]  rounds;
      logic [18:0] amap;
      logic [35:0] pmap;
      logic [63:0] pending [$];
      int          errors;

      function new();
         key_lo = '0; key_hi = '0; base_lo = '0; base_hi = '0;
         rounds = 4'd10; amap = '0; pmap = '0; errors = 0;
      endfunction

      function void write_reg(int unsigned idx, logic [63:0] v);
         case (idx)
            REG_KEY_LOW:     key_lo = v;
            REG_KEY_HIGH:    key_hi = v;
            REG_BASE_LOW:    base_lo = v;
            REG_BASE_HIGH:   base_hi = v;
            REG_ROUND_COUNT: rounds = v[3:0];
            REG_ACTIVE_MAP:  amap = v[18:0];
            REG_PASSIVE_MAP: pmap = v[35:0];
            default: ;
         endcase
      endfunction

      static function logic [7:0] xt(logic [7:0] v);
         return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
      endfunction

      function logic [63:0] encrypt(logic [31:0] vals);
         logic [7:0] b [16];
         logic [7:0] k [16];
         logic [7:0] t [16];
         logic [7:0] a0, a1, a2, a3, al;
         logic [63:0] res;
         int nr, na, np, pos;
         nr = rounds; if (nr < 1) nr = 1; if (nr > 10) nr = 10;
         na = amap[2:0]; if (na > 4) na = 4;
         np = pmap[3:0]; if (np > 8) np = 8;
         for (int i = 0; i < 8; i++) begin
            b[i] = base_lo[8*i +: 8]; b[i+8] = base_hi[8*i +: 8];
            k[i] = key_lo[8*i +: 8];  k[i+8] = key_hi[8*i +: 8];
         end
         for (int j = 0; j < na; j++) begin
            pos = amap[3 + 4*j +: 4];
            b[pos] = vals[8*j +: 8];
         end
         for (int i = 0; i < 16; i++) b[i] ^= k[i];
         for (int r = 1; r <= nr; r++) begin
            t[0] = SB[k[13]] ^ RC[r-1]; t[1] = SB[k[14]];
            t[2] = SB[k[15]];           t[3] = SB[k[12]];
            for (int i = 0; i < 4; i++) k[i] ^= t[i];
            for (int i = 4; i < 16; i++) k[i] ^= k[i-4];
            for (int c = 0; c < 4; c++)
               for (int rr = 0; rr < 4; rr++) t[rr + 4*c] = SB[b[rr + 4*((c + rr) % 4)]];
            b = t;
            if (r < nr) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = b[4*c]; a1 = b[4*c+1]; a2 = b[4*c+2]; a3 = b[4*c+3];
                  al = a0 ^ a1 ^ a2 ^ a3;
                  b[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
                  b[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
                  b[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
                  b[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
               end
            end
            for (int i = 0; i < 16; i++) b[i] ^= k[i];
         end
         res = '0;
         for (int j = 0; j < np; j++) begin
            pos = pmap[4 + 4*j +: 4];
            res[8*j +: 8] = b[pos];
         end
         return res;
      endfunction

      function void note_word(logic [31:0] vals);
         pending.push_back(encrypt(vals));
      endfunction

      function void check_word(logic [63:0] got);
         logic [63:0] exp;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
         end
         exp = pending.pop_front();
         if (exp !== got) begin
            errors++;
            if (errors <= 10) $display("partial_ct: expected %h, got %h", exp, got);
         end
      endfunction
   endclass

   logic        clock = 0, reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;
   int          cycles = 0;
   bit          in_done = 0;

   rrape_stream_if #(.WIDTH(32)) req ();
   rrape_stream_if #(.WIDTH(64)) rsp ();

   ct_scoreboard sb = new();

   reduced_round_aes_partial_encrypt dut (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   initial begin
      req.valid = 0; req.data = '0; rsp.ready = 0;
   end

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req.valid && req.ready) sb.note_word(req.data);
      if (!reset && rsp.valid && rsp.ready) sb.check_word(rsp.data);
      if (cycles > LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int gap_len();
      if ($urandom_range(0, 99) < 4) return $urandom_range(10, 40);
      if ($urandom_range(0, 99) < 40) return $urandom_range(1, 3);
      return 0;
   endfunction

   // Drain stalls on the result side.
   always begin
      int g;
      @(negedge clock);
      if (in_done && sb.pending.size() == 0) rsp.ready <= 1;
      else begin
         g = gap_len();
         if (g == 0 || $urandom_range(0, 3) != 0) rsp.ready <= 1;
         else begin
            rsp.ready <= 0;
            repeat (g - 1) @(negedge clock);
         end
      end
   end

   task automatic csr_write(int unsigned idx, logic [63:0] v);
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= 6'(8 * idx); csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   task automatic send_word(logic [31:0] v);
      int g;
      g = gap_len();
      if (g > 0) begin
         @(negedge clock);
         req.valid <= 0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req.valid <= 1; req.data <= v;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic rand_maps();
      logic [63:0] a, p;
      a = {$urandom, $urandom};
      p = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) a[2:0] = $urandom_range(0, 4);
      if ($urandom_range(0, 3) != 0) p[3:0] = $urandom_range(0, 8);
      csr_write(REG_ACTIVE_MAP, a);
      csr_write(REG_PASSIVE_MAP, p);
   endtask

   initial begin
      logic [31:0] v;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed: reset config, then extremes and repeated positions.
      send_word(32'h0); send_word(32'hFFFFFFFF);
      drain();
      csr_write(REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_BASE_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_BASE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_ROUND_COUNT, 64'd0);
      csr_write(REG_ACTIVE_MAP, {45'h0, 4'hF, 4'h0, 4'hF, 4'h0, 3'd4});
      csr_write(REG_PASSIVE_MAP, {28'h0, 4'hF, 4'h0, 4'h5, 4'h5, 4'hA, 4'h3, 4'hC, 4'h1, 4'hF, 4'd8});
      send_word(32'h0); send_word(32'hFFFFFFFF); send_word(32'hA5A5_5A5A);
      drain();
      csr_write(REG_ROUND_COUNT, 64'd15);
      csr_write(REG_ACTIVE_MAP, {45'h0, 4'h3, 4'h3, 4'h3, 4'h3, 3'd7});
      csr_write(REG_PASSIVE_MAP, {28'h0, 32'hFEDC_BA98, 4'hF});
      send_word(32'h1234_5678); send_word(32'hFFFFFFFF);
      drain();
      csr_write(REG_ROUND_COUNT, 64'd1);
      csr_write(REG_KEY_LOW, 64'h0);
      csr_write(REG_KEY_HIGH, 64'h0);
      csr_write(REG_ACTIVE_MAP, 64'h0);
      csr_write(REG_PASSIVE_MAP, 64'h0);
      send_word(32'hDEAD_BEEF);
      drain();
      csr_write(REG_PASSIVE_MAP, {28'h0, 32'h7654_3210, 4'd8});
      send_word(32'hDEAD_BEEF);
      drain();
      // Random phases of 50 words each.
      for (int ph = 0; ph < 20; ph++) begin
         csr_write(REG_KEY_LOW, {$urandom, $urandom});
         csr_write(REG_KEY_HIGH, {$urandom, $urandom});
         csr_write(REG_BASE_LOW, {$urandom, $urandom});
         csr_write(REG_BASE_HIGH, {$urandom, $urandom});
         csr_write(REG_ROUND_COUNT, (ph % 5 == 0) ? 64'd10 :
                   (ph % 5 == 1) ? 64'd1 : 64'($urandom_range(0, 15)));
         rand_maps();
         for (int i = 0; i < 50; i++) begin
            v = $urandom;
            send_word(v);
         end
         drain();
      end
      in_done = 1;
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule

FILE: sim.f
rtl/rrape_pkg.sv
rtl/rrape_stream_if.sv
rtl/rrape_round.sv
rtl/reduced_round_aes_partial_encrypt.sv
test/tb_reduced_round_aes_partial_encrypt.sv
